FILE: rtl/wrf_pkg.sv
// Shared constants for the waveform region finder.
`timescale 1ns / 1ps
`default_nettype none
package wrf_pkg;
  localparam int WindowDepth = 4096;
  localparam int AddrBits    = $clog2(WindowDepth);
  localparam int CountBits   = AddrBits + 1;
  localparam int MaxRegions  = 32;
  localparam int RegBits     = $clog2(MaxRegions);
  localparam int TotalBits   = RegBits + 1;
  localparam int SampleBits  = 16;
  localparam int ThrBits     = 15;
  localparam int PadBits     = 12;
  localparam int TailBits    = 8;
  localparam int SumBits     = SampleBits + TailBits + 1;
  localparam int IndexBits   = 12;

  localparam logic [2:0] CFG_START_THR = 3'd0;
  localparam logic [2:0] CFG_END_THR   = 3'd1;
  localparam logic [2:0] CFG_PRE_PAD   = 3'd2;
  localparam logic [2:0] CFG_POST_PAD  = 3'd3;
  localparam logic [2:0] CFG_TAIL      = 3'd4;
endpackage
`default_nettype wire

FILE: rtl/wrf_divider.sv
// Restoring divider of a signed tail sum by the tail length, truncating to zero.
`timescale 1ns / 1ps
`default_nettype none
module wrf_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          go,
  input  wire logic signed [wrf_pkg::SumBits-1:0] dividend,
  input  wire logic [wrf_pkg::CountBits-1:0] divisor,
  output logic                               done,
  output logic signed [wrf_pkg::SumBits-1:0] quotient
);
  import wrf_pkg::*;
  localparam int StepBits = $clog2(SumBits + 1);

  logic                 running;
  logic [StepBits-1:0]  steps;
  logic [SumBits-1:0]   mag;
  logic [SumBits-1:0]   quo;
  logic [CountBits:0]   rem;
  logic [CountBits-1:0] dvs;
  logic                 neg;
  logic [CountBits:0]   trial;
  logic [CountBits:0]   shifted;

  // One quotient bit per cycle.
  always_comb begin
    shifted = {rem[CountBits-1:0], mag[SumBits-1]};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        steps   <= StepBits'(SumBits);
        neg     <= dividend[SumBits-1];
        mag     <= dividend[SumBits-1] ? SumBits'(-dividend) : SumBits'(dividend);
        quo     <= '0;
        rem     <= '0;
        dvs     <= divisor;
      end else if (running) begin
        mag <= {mag[SumBits-2:0], 1'b0};
        if (!trial[CountBits]) begin
          rem <= trial;
          quo <= {quo[SumBits-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[SumBits-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == StepBits'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);
endmodule
`default_nettype wire

FILE: rtl/waveform_region_finder_unit.sv
// Top level of the waveform region finder: sample store, scan and merge sequencer.
// Loading stores one sample per accepted start; start stays accepted while busy is low.
// The final sample starts a pass: the mean of the last min(tail_count, n) samples
// when enabled, then the scan, padding and merge of each stored region, and a
// finishing step. Regions are emitted one per strobe; the receiver cannot stall.
// Reset is synchronous; registers return to their reset values and the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module waveform_region_finder_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [wrf_pkg::SampleBits-1:0] sample,
  input  wire logic                              final_sample,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [2:0]                        cfg_index,
  input  wire logic [31:0]                       cfg_data,
  output logic                                   strobe,
  output logic [wrf_pkg::IndexBits-1:0]          region_start,
  output logic [wrf_pkg::IndexBits-1:0]          region_end,
  output logic                                   region_last,
  output logic                                   overflow
);
  import wrf_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_TAIL  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_MERGE = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  // Configuration registers.
  logic [ThrBits-1:0]  start_thr;
  logic [ThrBits-1:0]  end_thr;
  logic [PadBits-1:0]  pre_pad;
  logic [PadBits-1:0]  post_pad;
  logic [TailBits-1:0] tail_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_thr  <= ThrBits'(300);
      end_thr    <= ThrBits'(100);
      pre_pad    <= '0;
      post_pad   <= '0;
      tail_count <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_THR: start_thr  <= cfg_data[ThrBits-1:0];
        CFG_END_THR:   end_thr    <= cfg_data[ThrBits-1:0];
        CFG_PRE_PAD:   pre_pad    <= cfg_data[PadBits-1:0];
        CFG_POST_PAD:  post_pad   <= cfg_data[PadBits-1:0];
        CFG_TAIL:      tail_count <= cfg_data[TailBits-1:0];
        default: ;
      endcase
    end
  end

  // Sample store and region tables.
  logic signed [SampleBits-1:0] store [WindowDepth];
  logic [IndexBits-1:0]         rstarts [MaxRegions];
  logic [IndexBits-1:0]         rends   [MaxRegions];

  logic [2:0]           state;
  logic [CountBits-1:0] count;
  logic [CountBits-1:0] ptr;
  logic [CountBits-1:0] issued;
  logic                 rd_valid;
  logic [CountBits-1:0] rd_idx;
  logic signed [SampleBits-1:0] rd_data;
  logic [AddrBits-1:0]  rd_addr;
  logic                 rd_en;
  logic signed [SumBits-1:0] tail_sum;
  logic signed [SumBits-1:0] mean;
  logic [CountBits-1:0] tlen;
  logic                 div_go;
  logic                 div_done;
  logic signed [SumBits-1:0] div_q;
  logic                 ropen;
  logic [IndexBits-1:0] open_at;
  logic [TotalBits-1:0] total;
  logic                 ovf;
  // Merge stage: region table read pointer and pending merged region.
  logic [TotalBits-1:0] k;
  logic                 tab_valid;
  logic [IndexBits-1:0] tab_s;
  logic [IndexBits-1:0] tab_e;
  logic                 have_pend;
  logic [IndexBits-1:0] pend_s;
  logic [IndexBits-1:0] pend_e;
  logic                 accept;
  logic                 add_en;
  logic [IndexBits-1:0] add_s;
  logic [IndexBits-1:0] add_e;
  logic signed [SampleBits+SumBits:0] level;
  logic [CountBits:0]   pad_end;
  logic [IndexBits-1:0] pad_s;
  logic [IndexBits-1:0] pad_e;
  logic [IndexBits-1:0] last_idx;

  assign busy   = (state != S_LOAD);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept && count < CountBits'(WindowDepth)) begin
      store[count[AddrBits-1:0]] <= sample;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (add_en) begin
      rstarts[total[RegBits-1:0]] <= add_s;
      rends[total[RegBits-1:0]]   <= add_e;
    end
    tab_s <= rstarts[k[RegBits-1:0]];
    tab_e <= rends[k[RegBits-1:0]];
  end

  wrf_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (tail_sum),
    .divisor  (tlen),
    .done     (div_done),
    .quotient (div_q)
  );

  // Hysteresis compare on the sample read back.
  assign level    = (SampleBits + SumBits + 1)'(rd_data) - (SampleBits + SumBits + 1)'(mean);
  assign last_idx = IndexBits'(count - 1'b1);
  assign rd_en    = (state == S_TAIL || state == S_SCAN) && issued < count &&
                    !(state == S_TAIL && issued >= tlen);
  assign rd_addr  = (state == S_TAIL) ? AddrBits'(count - 1'b1 - issued)
                                      : AddrBits'(issued);

  always_comb begin
    add_en = 1'b0;
    add_s  = open_at;
    add_e  = IndexBits'(rd_idx);
    if (state == S_SCAN) begin
      if (rd_valid && ropen && level < $signed({1'b0, end_thr})) begin
        add_en = total < TotalBits'(MaxRegions);
      end else if (!rd_valid && issued == count && ropen) begin
        add_en = total < TotalBits'(MaxRegions);
        add_e  = last_idx;
      end
    end
  end

  // Padding clamp on the table word read back.
  always_comb begin
    pad_s   = (tab_s > pre_pad) ? tab_s - pre_pad : '0;
    pad_end = (CountBits + 1)'(tab_e) + (CountBits + 1)'(post_pad);
    pad_e   = (pad_end >= {1'b0, count}) ? last_idx : IndexBits'(pad_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      count    <= '0;
      strobe   <= 1'b0;
      rd_valid <= 1'b0;
      div_go   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      div_go <= 1'b0;
      rd_valid <= rd_en;
      rd_idx   <= issued;
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (count < CountBits'(WindowDepth)) count <= count + 1'b1;
            if (final_sample) begin
              issued   <= '0;
              tail_sum <= '0;
              mean     <= '0;
              ropen    <= 1'b0;
              total    <= '0;
              ovf      <= 1'b0;
              if (count < CountBits'(WindowDepth)) begin
                tlen <= (CountBits'(tail_count) < count + 1'b1) ?
                        CountBits'(tail_count) : count + 1'b1;
              end else begin
                tlen <= (CountBits'(tail_count) < count) ? CountBits'(tail_count) : count;
              end
              state <= (tail_count != '0) ? S_TAIL : S_SCAN;
            end
          end
        end
        S_TAIL: begin
          if (rd_en) issued <= issued + 1'b1;
          if (rd_valid) tail_sum <= tail_sum + SumBits'(rd_data);
          if (!rd_en && !rd_valid) begin
            div_go <= 1'b1;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          issued <= '0;
          if (div_done) begin
            mean  <= div_q;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_en) issued <= issued + 1'b1;
          if (rd_valid) begin
            if (!ropen) begin
              if (level > $signed({1'b0, start_thr})) begin
                ropen   <= 1'b1;
                open_at <= IndexBits'(rd_idx);
              end
            end else if (level < $signed({1'b0, end_thr})) begin
              ropen <= 1'b0;
              if (add_en) total <= total + 1'b1;
              else ovf <= 1'b1;
            end
          end else if (issued == count) begin
            if (ropen) begin
              ropen <= 1'b0;
              if (add_en) total <= total + 1'b1;
              else ovf <= 1'b1;
            end
            k         <= '0;
            tab_valid <= 1'b0;
            have_pend <= 1'b0;
            state     <= S_MERGE;
          end
        end
        S_MERGE: begin
          // Alternate between reading a table word and using it; extend or flush the pending region.
          if (!tab_valid) begin
            if (k < total) begin
              tab_valid <= 1'b1;
            end else begin
              if (have_pend) begin
                strobe       <= 1'b1;
                region_start <= pend_s;
                region_end   <= pend_e;
                region_last  <= 1'b1;
                overflow     <= ovf;
              end
              state <= S_EMIT;
            end
          end else begin
            tab_valid <= 1'b0;
            k         <= k + 1'b1;
            if (have_pend && pad_s <= pend_e) begin
              pend_e <= pad_e;
            end else begin
              if (have_pend) begin
                strobe       <= 1'b1;
                region_start <= pend_s;
                region_end   <= pend_e;
                region_last  <= 1'b0;
                overflow     <= ovf;
              end
              have_pend <= 1'b1;
              pend_s    <= pad_s;
              pend_e    <= pad_e;
            end
          end
        end
        S_EMIT: begin
          count <= '0;
          state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the waveform region finder: load, scan, merge and emit.
`timescale 1ns / 1ps
module tb_top;
  import wrf_pkg::*;

  typedef struct packed {
    logic signed [SampleBits-1:0] value;
    logic                         last;
  } sample_word_t;

  typedef struct packed {
    logic [IndexBits-1:0] first;
    logic [IndexBits-1:0] stop;
    logic                 last;
    logic                 ovf;
  } region_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [SampleBits-1:0] sample = '0;
  logic final_sample = 1'b0;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = CFG_START_THR;
  logic [31:0] cfg_data = '0;
  logic busy, cfg_ready, strobe, region_last, overflow;
  logic [IndexBits-1:0] region_start, region_end;

  waveform_region_finder_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .final_sample(final_sample), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .strobe(strobe),
    .region_start(region_start), .region_end(region_end),
    .region_last(region_last), .overflow(overflow)
  );

  always #10 clk = ~clk;

  // Predictor state: configuration and the waveform being loaded.
  int unsigned thr_open = 300, thr_close = 100, pad_pre = 0, pad_post = 0, tail_len = 0;
  int wave_buf[WindowDepth];
  int unsigned wave_len = 0;

  sample_word_t pending_words[$];
  region_word_t expected_regions[$];
  int errors = 0;
  int unsigned words_sent = 0, regions_seen = 0, waveforms = 0;

  // Store a sample and, on the final one, work out the merged regions.
  function automatic void predict_regions(sample_word_t w);
    int unsigned n, t, k, j, open_at, nreg;
    int unsigned r_first[MaxRegions], r_stop[MaxRegions], s, e;
    longint sum, mean, v;
    bit is_open, ovf;
    region_word_t r;
    if (wave_len < WindowDepth) begin
      wave_buf[wave_len] = w.value;
      wave_len++;
    end
    if (!w.last) return;
    n = wave_len;
    mean = 0;
    nreg = 0;
    is_open = 0;
    ovf = 0;
    open_at = 0;
    if (tail_len != 0 && n != 0) begin
      t = (tail_len < n) ? tail_len : n;
      sum = 0;
      for (int i = 0; i < t; i++) sum += wave_buf[n - 1 - i];
      mean = sum / longint'(t);
    end
    for (int unsigned i = 0; i < n; i++) begin
      v = longint'(wave_buf[i]) - mean;
      if (!is_open) begin
        if (v > longint'(thr_open)) begin
          is_open = 1;
          open_at = i;
        end
      end else if (v < longint'(thr_close)) begin
        if (nreg < MaxRegions) begin
          r_first[nreg] = open_at;
          r_stop[nreg] = i;
          nreg++;
        end else ovf = 1;
        is_open = 0;
      end
    end
    if (is_open && n != 0) begin
      if (nreg < MaxRegions) begin
        r_first[nreg] = open_at;
        r_stop[nreg] = n - 1;
        nreg++;
      end else ovf = 1;
    end
    for (k = 0; k < nreg; k++) begin
      e = r_stop[k] + pad_post;
      r_first[k] = (r_first[k] > pad_pre) ? r_first[k] - pad_pre : 0;
      r_stop[k] = (e >= n) ? n - 1 : e;
    end
    k = 0;
    while (k < nreg) begin
      s = r_first[k];
      e = r_stop[k];
      j = k + 1;
      while (j < nreg && r_first[j] <= e) begin
        e = r_stop[j];
        j++;
      end
      r.first = s[IndexBits-1:0];
      r.stop = e[IndexBits-1:0];
      r.last = (j >= nreg);
      r.ovf = ovf;
      expected_regions = {expected_regions, r};
      k = j;
    end
    wave_len = 0;
    waveforms++;
  endfunction

  // Driver: bursts of words with random gaps between them.
  int gap_left = 0, burst_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        predict_regions(pending_words.pop_front());
        words_sent++;
      end
      if (start && busy) begin
        // hold the current word until accepted
      end else if (gap_left > 0 || pending_words.size() == 0) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        start <= 1'b1;
        sample <= pending_words[0].value;
        final_sample <= pending_words[0].last;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end
    end
  end

  // Monitor: compare each strobed region word with the oldest expectation.
  always @(posedge clk) begin
    region_word_t want;
    if (!rst && strobe) begin
      regions_seen++;
      if (expected_regions.size() == 0) begin
        $display("%0t: unexpected region word start=%0d end=%0d", $time,
                 region_start, region_end);
        errors++;
      end else begin
        want = expected_regions.pop_front();
        if (region_start !== want.first) begin
          $display("%0t: region_start expected %0d actual %0d", $time, want.first,
                   region_start);
          errors++;
        end
        if (region_end !== want.stop) begin
          $display("%0t: region_end expected %0d actual %0d", $time, want.stop,
                   region_end);
          errors++;
        end
        if (region_last !== want.last) begin
          $display("%0t: region_last expected %0b actual %0b", $time, want.last,
                   region_last);
          errors++;
        end
        if (overflow !== want.ovf) begin
          $display("%0t: overflow expected %0b actual %0b", $time, want.ovf,
                   overflow);
          errors++;
        end
      end
    end
  end

  // Write one register while the block is idle.
  task automatic write_reg(logic [2:0] idx, int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_START_THR: thr_open = val & 32'h7FFF;
      CFG_END_THR:   thr_close = val & 32'h7FFF;
      CFG_PRE_PAD:   pad_pre = val & 32'hFFF;
      CFG_POST_PAD:  pad_post = val & 32'hFFF;
      CFG_TAIL:      tail_len = val & 32'hFF;
      default: ;
    endcase
  endtask

  // Queue one waveform from a list of values.
  task automatic add_wave(int vals[$]);
    sample_word_t w;
    foreach (vals[i]) begin
      w.value = SampleBits'(vals[i]);
      w.last = (i == vals.size() - 1);
      pending_words = {pending_words, w};
    end
  endtask

  // Pulse waveform with random pulses over a small baseline.
  task automatic add_random_wave(int len, int pulses);
    int vals[$];
    int p, w, h, base;
    base = $urandom_range(0, 60) - 30;
    for (int i = 0; i < len; i++) vals = {vals, base + int'($urandom_range(0, 40)) - 20};
    for (int k = 0; k < pulses; k++) begin
      p = $urandom_range(0, len - 1);
      w = $urandom_range(1, 6);
      h = $urandom_range(150, 2000);
      for (int i = p; i < p + w && i < len; i++) vals[i] = base + h;
    end
    if ($urandom_range(0, 7) == 0) vals[$urandom_range(0, len - 1)] = $urandom_range(0, 65535);
    add_wave(vals);
  endtask

  // Wait until the block has emitted everything and settled.
  task automatic drain();
    while (pending_words.size() != 0 || start || busy || expected_regions.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    int v[$];
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, extremes, region at sample 0, open at end.
    add_wave('{32767, 0, -32768, 500, 500});
    add_wave('{400});
    add_wave('{0, 0, 0});
    add_wave('{-32768, 32767, -1, 301, 300, 99, 100});
    drain();
    write_reg(CFG_START_THR, 32767);
    write_reg(CFG_END_THR, 32767);
    write_reg(CFG_PRE_PAD, 4095);
    write_reg(CFG_POST_PAD, 4095);
    write_reg(CFG_TAIL, 255);
    add_wave('{32767, -32768, 32767, -32768});
    drain();
    write_reg(CFG_START_THR, 0);
    write_reg(CFG_END_THR, 0);
    write_reg(CFG_PRE_PAD, 1);
    write_reg(CFG_POST_PAD, 1);
    write_reg(CFG_TAIL, 2);
    add_wave('{1, 0, 5, -5, 7, 0, 3, 10});
    drain();

    // Table overflow: many narrow pulses.
    write_reg(CFG_START_THR, 300);
    write_reg(CFG_END_THR, 100);
    write_reg(CFG_PRE_PAD, 0);
    write_reg(CFG_POST_PAD, 0);
    write_reg(CFG_TAIL, 0);
    v = {};
    for (int i = 0; i < 80; i++) v = {v, (i % 2) ? 1000 : 0};
    add_wave(v);
    drain();

    // Random phases with different settings.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_START_THR, $urandom_range(100, 400));
      write_reg(CFG_END_THR, $urandom_range(0, 150));
      write_reg(CFG_PRE_PAD, $urandom_range(0, 4));
      write_reg(CFG_POST_PAD, (ph == 5) ? 4095 : $urandom_range(0, 4));
      write_reg(CFG_TAIL, (ph % 2) ? $urandom_range(1, 40) : 0);
      for (int k = 0; k < 3; k++) add_random_wave($urandom_range(4, 26), $urandom_range(0, 4));
      drain();
    end

    $display("Covered %0d words in %0d waveforms, %0d region words checked.",
             words_sent, waveforms, regions_seen);
    if (errors == 0) $display("waveform_region_finder_unit verification clean");
    else $display("waveform_region_finder_unit verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("waveform_region_finder_unit verification failed");
    $finish;
  end
endmodule
